// ===== sv/cpns_pkg.sv =====
package cpns_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int COUNT_W      = 5;
  localparam int CHAN_W       = 8;
  localparam int COLOR_W      = 3 * CHAN_W;
  localparam int KIND_W       = 2;
  localparam int POS_W        = 17;
  localparam int STEP_W       = 5;

  localparam logic [CHAN_W-1:0] LAND_RED_MIN = 8'd243;
  localparam logic [CHAN_W-1:0] LAND_GB_MAX  = 8'd12;

  localparam logic [KIND_W-1:0] KIND_SEGMENT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LAND    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd2;

  localparam logic [POS_W-1:0] POS_ONE = 17'h10000;

  localparam logic [STEP_W-1:0] CALC_LAST = 5'd18;
  localparam logic [STEP_W-1:0] DIV_LAST  = 5'd16;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_PRIME,
    OP_NEXT,
    OP_LEN,
    OP_DOT,
    OP_VV,
    OP_WW,
    OP_NUM_A,
    OP_NUM_B,
    OP_CUR_LO,
    OP_CUR_HI,
    OP_BST_LO,
    OP_BST_HI,
    OP_DECIDE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_FINISH,
    OP_WAIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic fast;
    logic seg_last;
    logic out_free;
  } status_t;

  // per-segment micro-op sequence
  function automatic cmd_t calc_cmd(input logic [STEP_W-1:0] step);
    cmd_t c;
    c.ch = CH_RED;
    c.op = OP_DECIDE;
    unique case (step)
      5'd0:  begin c.op = OP_LEN; c.ch = CH_RED; end
      5'd1:  begin c.op = OP_LEN; c.ch = CH_GREEN; end
      5'd2:  begin c.op = OP_LEN; c.ch = CH_BLUE; end
      5'd3:  begin c.op = OP_DOT; c.ch = CH_RED; end
      5'd4:  begin c.op = OP_DOT; c.ch = CH_GREEN; end
      5'd5:  begin c.op = OP_DOT; c.ch = CH_BLUE; end
      5'd6:  begin c.op = OP_VV; c.ch = CH_RED; end
      5'd7:  begin c.op = OP_VV; c.ch = CH_GREEN; end
      5'd8:  begin c.op = OP_VV; c.ch = CH_BLUE; end
      5'd9:  begin c.op = OP_WW; c.ch = CH_RED; end
      5'd10: begin c.op = OP_WW; c.ch = CH_GREEN; end
      5'd11: begin c.op = OP_WW; c.ch = CH_BLUE; end
      5'd12: c.op = OP_NUM_A;
      5'd13: c.op = OP_NUM_B;
      5'd14: c.op = OP_CUR_LO;
      5'd15: c.op = OP_CUR_HI;
      5'd16: c.op = OP_BST_LO;
      5'd17: c.op = OP_BST_HI;
      default: c.op = OP_DECIDE;
    endcase
    return c;
  endfunction

  function automatic logic [CHAN_W-1:0] chan(input logic [COLOR_W-1:0] v,
                                             input logic [1:0] ch);
    logic [CHAN_W-1:0] r;
    unique case (ch)
      CH_RED:   r = v[23:16];
      CH_GREEN: r = v[15:8];
      default:  r = v[7:0];
    endcase
    return r;
  endfunction

endpackage

// ===== sv/cpns_in_if.sv =====
interface cpns_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [cpns_pkg::VIDX_W-1:0]  vertex_index;
  logic [cpns_pkg::CHAN_W-1:0]  red;
  logic [cpns_pkg::CHAN_W-1:0]  green;
  logic [cpns_pkg::CHAN_W-1:0]  blue;

  modport source (output valid, command, vertex_index, red, green, blue, input ready);
  modport sink (input valid, command, vertex_index, red, green, blue, output ready);
endinterface

// ===== sv/cpns_out_if.sv =====
interface cpns_out_if;
  logic                         valid;
  logic                         ready;
  logic [cpns_pkg::KIND_W-1:0]  result_kind;
  logic [cpns_pkg::VIDX_W-1:0]  segment_index;
  logic [cpns_pkg::POS_W-1:0]   position;

  modport source (output valid, result_kind, segment_index, position, input ready);
  modport sink (input valid, result_kind, segment_index, position, output ready);
endinterface

// ===== sv/cpns_cfg_if.sv =====
interface cpns_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cpns_pkg::COUNT_W-1:0]  vertex_count;

  modport source (output valid, vertex_count, input ready);
  modport sink (input valid, vertex_count, output ready);
endinterface

// ===== sv/cpns_ram.sv =====
module cpns_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/cpns_datapath.sv =====
module cpns_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  cpns_pkg::cmd_t                cmd,
  output cpns_pkg::status_t             status,
  input  logic                          in_fire,
  input  logic                          in_command,
  input  logic [cpns_pkg::VIDX_W-1:0]   in_vertex_index,
  input  logic [cpns_pkg::CHAN_W-1:0]   in_red,
  input  logic [cpns_pkg::CHAN_W-1:0]   in_green,
  input  logic [cpns_pkg::CHAN_W-1:0]   in_blue,
  cpns_cfg_if.sink                      cfg,
  cpns_out_if.source                    result
);
  logic [cpns_pkg::COUNT_W-1:0] vcount;
  logic [cpns_pkg::COUNT_W-1:0] used;
  logic [cpns_pkg::COLOR_W-1:0] pix, p0, p1, rdata;
  logic                         land;
  logic [cpns_pkg::VIDX_W-1:0]  seg, raddr;
  logic [17:0]                  len, vv, ww;
  logic signed [18:0]           dot;
  logic signed [37:0]           numm;
  logic [53:0]                  cur, bst;
  logic [35:0]                  best_num, cnum;
  logic [17:0]                  best_den, cden, best_dot, best_len;
  logic [cpns_pkg::VIDX_W-1:0]  best_seg;
  logic                         best_mid, best_hi, found;
  logic [17:0]                  rem;
  logic [15:0]                  quo;
  logic                         out_valid;
  logic [cpns_pkg::KIND_W-1:0]  out_kind;
  logic [cpns_pkg::VIDX_W-1:0]  out_seg;
  logic [cpns_pkg::POS_W-1:0]   out_pos;
  logic [8:0]                   dc, vc, wc;
  logic signed [18:0]           ma, mb;
  logic signed [37:0]           prod;
  logic                         dle0, dge, mid;
  logic [18:0]                  r2;
  logic                         r2ge;
  logic                         pix_land;

  cpns_ram #(.WIDTH(cpns_pkg::COLOR_W), .DEPTH(cpns_pkg::MAX_VERTICES)) u_table (
    .clk   (clk),
    .we    (in_fire && !in_command),
    .waddr (in_vertex_index),
    .wdata ({in_red, in_green, in_blue}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cfg.ready = 1'b1;
  assign used = (vcount > cpns_pkg::COUNT_W'(cpns_pkg::MAX_VERTICES))
              ? cpns_pkg::COUNT_W'(cpns_pkg::MAX_VERTICES) : vcount;

  always_comb begin
    unique case (cmd.op)
      cpns_pkg::OP_IDLE:  raddr = '0;
      cpns_pkg::OP_PRIME: raddr = cpns_pkg::VIDX_W'(1);
      default:            raddr = seg + cpns_pkg::VIDX_W'(2);
    endcase
  end

  assign pix_land = (in_red >= cpns_pkg::LAND_RED_MIN) && (in_green <= cpns_pkg::LAND_GB_MAX)
                 && (in_blue <= cpns_pkg::LAND_GB_MAX);

  // per-channel differences
  assign dc = {1'b0, cpns_pkg::chan(p1, cmd.ch)} - {1'b0, cpns_pkg::chan(p0, cmd.ch)};
  assign vc = {1'b0, cpns_pkg::chan(pix, cmd.ch)} - {1'b0, cpns_pkg::chan(p0, cmd.ch)};
  assign wc = {1'b0, cpns_pkg::chan(pix, cmd.ch)} - {1'b0, cpns_pkg::chan(p1, cmd.ch)};

  // clamp case of the current segment
  assign dle0 = dot[18] || (dot == '0);
  assign dge  = !dot[18] && (dot[17:0] >= len);
  assign mid  = !dle0 && !dge;
  assign cnum = dle0 ? {18'd0, vv} : (dge ? {18'd0, ww} : numm[35:0]);
  assign cden = mid ? len : 18'd1;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      cpns_pkg::OP_LEN:    begin ma = {{10{dc[8]}}, dc}; mb = {{10{dc[8]}}, dc}; end
      cpns_pkg::OP_DOT:    begin ma = {{10{vc[8]}}, vc}; mb = {{10{dc[8]}}, dc}; end
      cpns_pkg::OP_VV:     begin ma = {{10{vc[8]}}, vc}; mb = {{10{vc[8]}}, vc}; end
      cpns_pkg::OP_WW:     begin ma = {{10{wc[8]}}, wc}; mb = {{10{wc[8]}}, wc}; end
      cpns_pkg::OP_NUM_A:  begin ma = {1'b0, vv}; mb = {1'b0, len}; end
      cpns_pkg::OP_NUM_B:  begin ma = dot; mb = dot; end
      cpns_pkg::OP_CUR_LO: begin ma = {1'b0, cnum[17:0]}; mb = {1'b0, best_den}; end
      cpns_pkg::OP_CUR_HI: begin ma = {1'b0, cnum[35:18]}; mb = {1'b0, best_den}; end
      cpns_pkg::OP_BST_LO: begin ma = {1'b0, best_num[17:0]}; mb = {1'b0, cden}; end
      cpns_pkg::OP_BST_HI: begin ma = {1'b0, best_num[35:18]}; mb = {1'b0, cden}; end
      default: ;
    endcase
  end

  assign prod = ma * mb;
  assign r2   = {rem, 1'b0};
  assign r2ge = r2 >= {1'b0, best_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount    <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
      seg       <= '0;
    end else begin
      if (cfg.valid) begin
        vcount <= cfg.vertex_count;
      end
      // a new result beat replaces one that is taken in the same cycle
      if (cmd.op == cpns_pkg::OP_FINISH) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire && in_command) begin
        seg   <= '0;
        found <= 1'b0;
      end
      unique case (cmd.op)
        cpns_pkg::OP_DECIDE: begin
          seg <= seg + cpns_pkg::VIDX_W'(1);
          if (len != '0 && (!found || cur < bst)) begin
            found <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_command) begin
      pix      <= {in_red, in_green, in_blue};
      land     <= pix_land;
      best_num <= '0;
      best_den <= 18'd1;
    end
    unique case (cmd.op)
      cpns_pkg::OP_PRIME: p1 <= rdata;
      cpns_pkg::OP_NEXT: begin
        p0  <= p1;
        p1  <= rdata;
        len <= '0;
        dot <= '0;
        vv  <= '0;
        ww  <= '0;
      end
      cpns_pkg::OP_LEN:    len  <= len + prod[17:0];
      cpns_pkg::OP_DOT:    dot  <= dot + prod[18:0];
      cpns_pkg::OP_VV:     vv   <= vv + prod[17:0];
      cpns_pkg::OP_WW:     ww   <= ww + prod[17:0];
      cpns_pkg::OP_NUM_A:  numm <= prod;
      cpns_pkg::OP_NUM_B:  numm <= numm - prod;
      cpns_pkg::OP_CUR_LO: cur  <= {17'd0, prod[36:0]};
      cpns_pkg::OP_CUR_HI: cur  <= cur + {prod[35:0], 18'd0};
      cpns_pkg::OP_BST_LO: bst  <= {17'd0, prod[36:0]};
      cpns_pkg::OP_BST_HI: bst  <= bst + {prod[35:0], 18'd0};
      cpns_pkg::OP_DECIDE: begin
        if (len != '0 && (!found || cur < bst)) begin
          best_num <= cnum;
          best_den <= cden;
          best_seg <= seg;
          best_dot <= dot[17:0];
          best_len <= len;
          best_mid <= mid;
          best_hi  <= dge;
        end
      end
      cpns_pkg::OP_DIV_INIT: begin
        rem <= best_dot;
        quo <= '0;
      end
      cpns_pkg::OP_DIV_STEP: begin
        rem <= r2ge ? 18'(r2 - {1'b0, best_len}) : r2[17:0];
        quo <= {quo[14:0], r2ge};
      end
      cpns_pkg::OP_FINISH: begin
        if (land) begin
          out_kind <= cpns_pkg::KIND_LAND;
          out_seg  <= '0;
          out_pos  <= '0;
        end else if (!found) begin
          out_kind <= cpns_pkg::KIND_NONE;
          out_seg  <= '0;
          out_pos  <= '0;
        end else begin
          out_kind <= cpns_pkg::KIND_SEGMENT;
          out_seg  <= best_seg;
          out_pos  <= best_mid ? {1'b0, quo} : (best_hi ? cpns_pkg::POS_ONE : '0);
        end
      end
      default: ;
    endcase
  end

  assign result.valid         = out_valid;
  assign result.result_kind   = out_kind;
  assign result.segment_index = out_seg;
  assign result.position      = out_pos;

  assign status.fast     = land || (used < cpns_pkg::COUNT_W'(2));
  assign status.seg_last = {1'b0, seg} == (used - cpns_pkg::COUNT_W'(2));
  assign status.out_free = !out_valid || result.ready;
endmodule

// ===== sv/cpns_ctrl.sv =====
module cpns_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_ready,
  input  cpns_pkg::status_t    status,
  output cpns_pkg::cmd_t       cmd
);
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PRIME = 6'b000010,
    ST_NEXT  = 6'b000100,
    ST_CALC  = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                        state, state_next;
  logic [cpns_pkg::STEP_W-1:0]   step, step_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd.ch     = cpns_pkg::CH_RED;
    cmd.op     = cpns_pkg::OP_IDLE;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_command) begin
          state_next = ST_PRIME;
        end
      end
      ST_PRIME: begin
        cmd.op     = cpns_pkg::OP_PRIME;
        state_next = status.fast ? ST_DONE : ST_NEXT;
      end
      ST_NEXT: begin
        cmd.op     = cpns_pkg::OP_NEXT;
        step_next  = '0;
        state_next = ST_CALC;
      end
      ST_CALC: begin
        cmd       = cpns_pkg::calc_cmd(step);
        step_next = step + cpns_pkg::STEP_W'(1);
        if (step == cpns_pkg::CALC_LAST) begin
          step_next  = '0;
          state_next = status.seg_last ? ST_DIV : ST_NEXT;
        end
      end
      ST_DIV: begin
        cmd.op    = (step == '0) ? cpns_pkg::OP_DIV_INIT : cpns_pkg::OP_DIV_STEP;
        step_next = step + cpns_pkg::STEP_W'(1);
        if (step == cpns_pkg::DIV_LAST) begin
          step_next  = '0;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.op     = cpns_pkg::OP_FINISH;
          state_next = ST_IDLE;
        end else begin
          cmd.op = cpns_pkg::OP_WAIT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end
endmodule

// ===== sv/color_polyline_nearest_segment.sv =====
// Maps an RGB pixel to the nearest segment of a color polyline held in a
// 16-entry vertex table. A load beat (command 0) writes one vertex and
// returns nothing. A classify beat (command 1) returns one result beat:
// land for nearly pure red, otherwise the nearest non-degenerate segment with
// its clamped Q1.16 position, or "no usable segment". Land or fewer than
// two vertices skip the segment walk; otherwise each segment in use is
// worked by a single shared 19x19 multiply-accumulate unit that works one
// product per cycle, and a 16-step restoring divider then runs once for the
// winning segment. The next beat is taken once the block is back in idle,
// even if the last result beat still waits to be taken. Write vertex_count
// only while the block is idle.
module color_polyline_nearest_segment (
  input  logic       clk,
  input  logic       rst,
  cpns_in_if.sink    pixel,
  cpns_cfg_if.sink   cfg,
  cpns_out_if.source result
);
  cpns_pkg::cmd_t    cmd;
  cpns_pkg::status_t status;
  logic              in_ready;
  logic              in_fire;

  // input beats are only taken in idle
  assign pixel.ready = in_ready;
  assign in_fire     = pixel.valid && in_ready;

  // sequencer: walks segments, issues one datapath op per cycle
  cpns_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pixel.valid),
    .in_command (pixel.command),
    .in_ready   (in_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // vertex table, shared mac, divider, best tracker and output register
  cpns_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_fire         (in_fire),
    .in_command      (pixel.command),
    .in_vertex_index (pixel.vertex_index),
    .in_red          (pixel.red),
    .in_green        (pixel.green),
    .in_blue         (pixel.blue),
    .cfg             (cfg),
    .result          (result)
  );
endmodule
